// ----- design/kcet_pkg.sv -----
`default_nettype none
package kcet_pkg;

  // Coordinate and output formats
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int IN_WIDTH    = 32;
  localparam int OUT_WIDTH   = 48;

  // Internal widths, derived from the coordinate width, the fraction bits and the output width
  localparam int CW   = COORD_WIDTH;
  localparam int PW   = 2 * CW;          // one coordinate product
  localparam int MW   = PW + 1;          // m and o
  localparam int NPW  = PW + 2;          // n / 2
  localparam int AMW  = PW;              // magnitude of m and o
  localparam int ANW  = PW + 1;          // magnitude of n / 2
  localparam int NSQW = 2 * ANW;         // (n / 2)^2
  localparam int MOW  = 2 * AMW;         // |m * o|
  localparam int DPW  = 2 * PW + 3;      // delta / 4, signed
  localparam int RW   = DPW + 1;         // radicand, unsigned, even width
  localparam int SW   = RW / 2;          // square root
  localparam int AW   = PW + 3;          // numerator addend
  localparam int DENW = PW + 3;          // denominator
  localparam int NUMW = PW + 4;          // numerator before scaling
  localparam int QNW  = NUMW + FRAC_BITS;
  localparam int QB   = OUT_WIDTH;       // quotient bits

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NO_ROOT    = 2'd1,
    STATUS_DEGENERATE = 2'd2
  } status_e;

  // Result class of one item, settled before the root is taken
  typedef struct packed {
    logic    do_div;
    logic    inf;
    status_e st;
  } ctl_t;

  // Data that rides along the square root pipeline
  typedef struct packed {
    ctl_t                   ctl;
    logic                   use_s;
    logic signed [AW-1:0]   addend;
    logic signed [DENW-1:0] den;
  } side_t;

endpackage
`default_nettype wire

// ----- design/kinetic_certificate_expiry_time.sv -----
// Pipeline: the result strobe follows the accepting edge through 6 setup stages, 66 square root stages,
// 3 divider setup stages, 48 quotient stages and 1 output register.
// Throughput: one item per cycle; busy_o stays low, one bit-step per stage in root and divider.
// Reset: clears all valid bits at once; items in flight are dropped, no result follows.
// Results are shown for one cycle with done_o; the receiver cannot stall.
`default_nettype none
module kinetic_certificate_expiry_time (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 a_has_partner_i,
  input  logic                                 b_has_partner_i,
  input  logic signed [kcet_pkg::IN_WIDTH-1:0] a_dvx_i,
  input  logic signed [kcet_pkg::IN_WIDTH-1:0] a_dx0_i,
  input  logic signed [kcet_pkg::IN_WIDTH-1:0] a_dvy_i,
  input  logic signed [kcet_pkg::IN_WIDTH-1:0] a_dy0_i,
  input  logic signed [kcet_pkg::IN_WIDTH-1:0] b_dvx_i,
  input  logic signed [kcet_pkg::IN_WIDTH-1:0] b_dx0_i,
  input  logic signed [kcet_pkg::IN_WIDTH-1:0] b_dvy_i,
  input  logic signed [kcet_pkg::IN_WIDTH-1:0] b_dy0_i,
  output logic                                 done_o,
  output logic signed [kcet_pkg::OUT_WIDTH-1:0] expiry_time_o,
  output logic                                 is_infinite_o,
  output logic [1:0]                           status_o
);

  localparam int IW   = kcet_pkg::IN_WIDTH;
  localparam int CW   = kcet_pkg::CW;
  localparam int PW   = kcet_pkg::PW;
  localparam int MW   = kcet_pkg::MW;
  localparam int NPW  = kcet_pkg::NPW;
  localparam int AMW  = kcet_pkg::AMW;
  localparam int ANW  = kcet_pkg::ANW;
  localparam int NSQW = kcet_pkg::NSQW;
  localparam int MOW  = kcet_pkg::MOW;
  localparam int DPW  = kcet_pkg::DPW;
  localparam int RW   = kcet_pkg::RW;
  localparam int SW   = kcet_pkg::SW;
  localparam int AW   = kcet_pkg::AW;
  localparam int DENW = kcet_pkg::DENW;
  localparam int NUMW = kcet_pkg::NUMW;

  function automatic logic signed [CW-1:0] coord(input logic [IW-1:0] raw);
    logic [IW+CW-1:0] ext;
    ext = {{CW{1'b0}}, raw};
    return ext[CW-1:0];
  endfunction

  logic accept;
  assign accept = start_i && !busy_o;
  assign busy_o = 1'b0;

  // Stage 1: the twelve coordinate products
  logic signed [CW-1:0] c [8];
  logic signed [PW-1:0] p1_q [12];
  logic                 s1_vld_q;
  logic                 s1_pok_q;

  always_comb begin
    c[0] = coord(a_dvx_i);
    c[1] = coord(a_dx0_i);
    c[2] = coord(a_dvy_i);
    c[3] = coord(a_dy0_i);
    c[4] = coord(b_dvx_i);
    c[5] = coord(b_dx0_i);
    c[6] = coord(b_dvy_i);
    c[7] = coord(b_dy0_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pok_q  <= a_has_partner_i && b_has_partner_i;
    p1_q[0]   <= c[0] * c[0];
    p1_q[1]   <= c[2] * c[2];
    p1_q[2]   <= c[4] * c[4];
    p1_q[3]   <= c[6] * c[6];
    p1_q[4]   <= c[0] * c[1];
    p1_q[5]   <= c[2] * c[3];
    p1_q[6]   <= c[4] * c[5];
    p1_q[7]   <= c[6] * c[7];
    p1_q[8]   <= c[1] * c[1];
    p1_q[9]   <= c[3] * c[3];
    p1_q[10]  <= c[5] * c[5];
    p1_q[11]  <= c[7] * c[7];
  end

  // Stage 2: m, n/2 and o
  logic                  s2_vld_q;
  logic                  s2_pok_q;
  logic signed [MW-1:0]  m2_q;
  logic signed [NPW-1:0] np2_q;
  logic signed [MW-1:0]  o2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_pok_q <= s1_pok_q;
    m2_q  <= MW'(p1_q[0]) + MW'(p1_q[1]) - MW'(p1_q[2]) - MW'(p1_q[3]);
    np2_q <= NPW'(p1_q[4]) + NPW'(p1_q[5]) - NPW'(p1_q[6]) - NPW'(p1_q[7]);
    o2_q  <= MW'(p1_q[8]) + MW'(p1_q[9]) - MW'(p1_q[10]) - MW'(p1_q[11]);
  end

  // Stage 3: magnitudes, sign flags, divider operands
  logic                   s3_vld_q;
  logic                   s3_pok_q, s3_mz_q, s3_mneg_q, s3_nz_q, s3_nneg_q, s3_opos_q;
  logic                   s3_moneg_q;
  logic [AMW-1:0]         am3_q, ao3_q;
  logic [ANW-1:0]         an3_q;
  logic signed [AW-1:0]   add3_q;
  logic signed [DENW-1:0] den3_q;
  logic [MW-1:0]          mu, ou, mabs, oabs;
  logic [NPW-1:0]         nu, nabs;
  logic                   mz;
  logic signed [AW-1:0]   o_ext, n2_ext;
  logic signed [DENW-1:0] m2_ext, n2_den;

  always_comb begin
    mu     = m2_q;
    ou     = o2_q;
    nu     = np2_q;
    mabs   = mu[MW-1] ? (~mu + 1'b1) : mu;
    oabs   = ou[MW-1] ? (~ou + 1'b1) : ou;
    nabs   = nu[NPW-1] ? (~nu + 1'b1) : nu;
    mz     = (m2_q == '0);
    o_ext  = AW'(o2_q);
    n2_ext = AW'(np2_q) <<< 1;
    m2_ext = DENW'(m2_q) <<< 1;
    n2_den = DENW'(np2_q) <<< 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_pok_q   <= s2_pok_q;
    s3_mz_q    <= mz;
    s3_mneg_q  <= mu[MW-1];
    s3_nz_q    <= (np2_q == '0);
    s3_nneg_q  <= nu[NPW-1];
    s3_opos_q  <= !ou[MW-1] && (o2_q != '0);
    s3_moneg_q <= mu[MW-1] ^ ou[MW-1];
    am3_q      <= mabs[AMW-1:0];
    ao3_q      <= oabs[AMW-1:0];
    an3_q      <= nabs[ANW-1:0];
    add3_q     <= mz ? -o_ext : -n2_ext;
    den3_q     <= mz ? n2_den : m2_ext;
  end

  // Stage 4: partial products of (n/2)^2 and |m*o|
  logic                   s4_vld_q;
  logic                   s4_pok_q, s4_mz_q, s4_mneg_q, s4_nz_q, s4_nneg_q, s4_opos_q;
  logic                   s4_moneg_q;
  logic [2*CW-1:0]        hh4_q;
  logic [2*CW:0]          hl4_q;
  logic [2*CW+1:0]        ll4_q;
  logic [2*CW-1:0]        mo4_q [4];
  logic signed [AW-1:0]   add4_q;
  logic signed [DENW-1:0] den4_q;
  logic [CW-1:0]          n_hi;
  logic [CW:0]            n_lo;

  always_comb begin
    n_hi = an3_q[ANW-1:CW+1];
    n_lo = an3_q[CW:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_pok_q   <= s3_pok_q;
    s4_mz_q    <= s3_mz_q;
    s4_mneg_q  <= s3_mneg_q;
    s4_nz_q    <= s3_nz_q;
    s4_nneg_q  <= s3_nneg_q;
    s4_opos_q  <= s3_opos_q;
    s4_moneg_q <= s3_moneg_q;
    hh4_q      <= n_hi * n_hi;
    hl4_q      <= (2*CW+1)'(n_hi) * (2*CW+1)'(n_lo);
    ll4_q      <= (2*CW+2)'(n_lo) * (2*CW+2)'(n_lo);
    mo4_q[0]   <= am3_q[AMW-1:CW] * ao3_q[AMW-1:CW];
    mo4_q[1]   <= am3_q[AMW-1:CW] * ao3_q[CW-1:0];
    mo4_q[2]   <= am3_q[CW-1:0] * ao3_q[AMW-1:CW];
    mo4_q[3]   <= am3_q[CW-1:0] * ao3_q[CW-1:0];
    add4_q     <= add3_q;
    den4_q     <= den3_q;
  end

  // Stage 5: assemble (n/2)^2 and |m*o|
  logic                   s5_vld_q;
  logic                   s5_pok_q, s5_mz_q, s5_mneg_q, s5_nz_q, s5_nneg_q, s5_opos_q;
  logic                   s5_moneg_q;
  logic [NSQW-1:0]        nsq5_q;
  logic [MOW-1:0]         mo5_q;
  logic signed [AW-1:0]   add5_q;
  logic signed [DENW-1:0] den5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_pok_q   <= s4_pok_q;
    s5_mz_q    <= s4_mz_q;
    s5_mneg_q  <= s4_mneg_q;
    s5_nz_q    <= s4_nz_q;
    s5_nneg_q  <= s4_nneg_q;
    s5_opos_q  <= s4_opos_q;
    s5_moneg_q <= s4_moneg_q;
    nsq5_q     <= (NSQW'(hh4_q) << (2*CW+2)) + (NSQW'(hl4_q) << (CW+2)) + NSQW'(ll4_q);
    mo5_q      <= (MOW'(mo4_q[0]) << (2*CW)) + ((MOW'(mo4_q[1]) + MOW'(mo4_q[2])) << CW)
                  + MOW'(mo4_q[3]);
    add5_q     <= add4_q;
    den5_q     <= den4_q;
  end

  // Stage 6: discriminant, radicand and result class
  logic            s6_vld_q;
  logic [RW-1:0]   rad6_q;
  kcet_pkg::side_t side6_q;
  logic [DPW-1:0]  dp;
  logic            dpos;
  kcet_pkg::ctl_t  ctl_d;

  always_comb begin
    dp    = s5_moneg_q ? (DPW'(nsq5_q) + DPW'(mo5_q)) : (DPW'(nsq5_q) - DPW'(mo5_q));
    dpos  = !dp[DPW-1] && (dp != '0);
    ctl_d = '{do_div: 1'b0, inf: 1'b0, st: kcet_pkg::STATUS_OK};
    if (!s5_pok_q) begin
      ctl_d.inf = 1'b1;
    end else if (!s5_mz_q) begin
      if (dpos) begin
        ctl_d.do_div = 1'b1;
      end else if (s5_mneg_q) begin
        ctl_d.inf = 1'b1;
      end else begin
        ctl_d.st = kcet_pkg::STATUS_NO_ROOT;
      end
    end else if (s5_nz_q) begin
      if (s5_opos_q) begin
        ctl_d.st = kcet_pkg::STATUS_DEGENERATE;
      end else begin
        ctl_d.inf = 1'b1;
      end
    end else if (s5_nneg_q) begin
      ctl_d.inf = 1'b1;
    end else begin
      ctl_d.do_div = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rad6_q         <= dpos ? {dp[DPW-2:0], 2'b00} : '0;
    side6_q.ctl    <= ctl_d;
    side6_q.use_s  <= !s5_mz_q;
    side6_q.addend <= add5_q;
    side6_q.den    <= den5_q;
  end

  // Square root of the discriminant
  logic            sq_vld;
  logic [SW-1:0]   sq_root;
  kcet_pkg::side_t sq_side;

  kcet_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s6_vld_q),
    .rad_i  (rad6_q),
    .side_i (side6_q),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // Numerator: add the root unless m is zero
  logic                   d0_vld_q;
  logic signed [NUMW-1:0] num_q;
  logic signed [DENW-1:0] den_q;
  kcet_pkg::ctl_t         ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d0_vld_q <= 1'b0;
    end else begin
      d0_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= NUMW'(sq_side.addend) + (sq_side.use_s ? NUMW'(sq_root) : '0);
    den_q <= sq_side.den;
    ctl_q <= sq_side.ctl;
  end

  // Floored, saturated quotient and output register
  kcet_pkg::status_e st_w;

  kcet_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (d0_vld_q),
    .num_i  (num_q),
    .den_i  (den_q),
    .ctl_i  (ctl_q),
    .vld_o  (done_o),
    .t_o    (expiry_time_o),
    .inf_o  (is_infinite_o),
    .st_o   (st_w)
  );

  assign status_o = st_w;

  // An infinite result carries no time and no error
  a_inf_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && is_infinite_o |-> expiry_time_o == '0 && st_w == kcet_pkg::STATUS_OK)
    else $error("infinite result with time or status");

  // An error result is finite and carries no time
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && st_w != kcet_pkg::STATUS_OK |-> !is_infinite_o && expiry_time_o == '0)
    else $error("error result with time or infinite flag");

  // An accepted item enters the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_vld_q)
    else $error("accepted item lost at entry");

  // A class never asks for a division together with infinity
  a_ctl_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s6_vld_q |-> !(side6_q.ctl.do_div && side6_q.ctl.inf))
    else $error("division requested for infinite result");

endmodule
`default_nettype wire

// ----- design/kcet_sqrt.sv -----
`default_nettype none
module kcet_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  logic [kcet_pkg::RW-1:0]    rad_i,
  input  kcet_pkg::side_t            side_i,
  output logic                       vld_o,
  output logic [kcet_pkg::SW-1:0]    root_o,
  output kcet_pkg::side_t            side_o
);

  localparam int RW = kcet_pkg::RW;
  localparam int SW = kcet_pkg::SW;

  logic                 vld_s  [SW+1];
  logic [RW-1:0]        rad_s  [SW+1];
  logic [SW+1:0]        rem_s  [SW+1];
  logic [SW-1:0]        root_s [SW+1];
  kcet_pkg::side_t      side_s [SW+1];

  // Feed the first step
  assign vld_s[0]  = vld_i;
  assign rad_s[0]  = rad_i;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign side_s[0] = side_i;

  // One root bit per stage: bring down two radicand bits, try root*4+1
  for (genvar k = 1; k <= SW; k++) begin : g_step
    logic [SW+3:0] r2;
    logic [SW+3:0] trial;
    logic          ge;

    assign r2    = {rem_s[k-1], rad_s[k-1][RW-1:RW-2]};
    assign trial = (SW+4)'({root_s[k-1], 2'b01});
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[k] <= 1'b0;
      end else begin
        vld_s[k] <= vld_s[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rad_s[k]  <= {rad_s[k-1][RW-3:0], 2'b00};
      rem_s[k]  <= ge ? (SW+2)'(r2 - trial) : r2[SW+1:0];
      root_s[k] <= {root_s[k-1][SW-2:0], ge};
      side_s[k] <= side_s[k-1];
    end
  end

  assign vld_o  = vld_s[SW];
  assign root_o = root_s[SW];
  assign side_o = side_s[SW];

endmodule
`default_nettype wire

// ----- design/kcet_div.sv -----
`default_nettype none
module kcet_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                vld_i,
  input  logic signed [kcet_pkg::NUMW-1:0]    num_i,
  input  logic signed [kcet_pkg::DENW-1:0]    den_i,
  input  kcet_pkg::ctl_t                      ctl_i,
  output logic                                vld_o,
  output logic signed [kcet_pkg::QB-1:0]      t_o,
  output logic                                inf_o,
  output kcet_pkg::status_e                   st_o
);

  localparam int NUMW = kcet_pkg::NUMW;
  localparam int DENW = kcet_pkg::DENW;
  localparam int QNW  = kcet_pkg::QNW;
  localparam int QB   = kcet_pkg::QB;
  localparam int FB   = kcet_pkg::FRAC_BITS;
  localparam int EXW  = DENW + QB + QNW;
  localparam logic [QB:0] TMAX_MAG = {2'b00, {(QB-1){1'b1}}};
  localparam logic [QB:0] TMIN_MAG = {2'b01, {(QB-1){1'b0}}};

  // Magnitudes and quotient sign
  logic              a_vld_q;
  logic [QNW-1:0]    a_num_q;
  logic [DENW-1:0]   a_den_q;
  logic              a_neg_q;
  kcet_pkg::ctl_t    a_ctl_q;
  logic [NUMW-1:0]   num_u;
  logic [DENW-1:0]   den_u;
  logic [NUMW-1:0]   num_mag;
  logic [DENW-1:0]   den_mag;

  always_comb begin
    num_u   = num_i;
    den_u   = den_i;
    num_mag = num_u[NUMW-1] ? (~num_u + 1'b1) : num_u;
    den_mag = den_u[DENW-1] ? (~den_u + 1'b1) : den_u;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_num_q <= {num_mag, {FB{1'b0}}};
    a_den_q <= den_mag;
    a_neg_q <= num_u[NUMW-1] ^ den_u[DENW-1];
    a_ctl_q <= ctl_i;
  end

  // Long division chain, index 0 holds the overflow check and first remainder
  logic              vld_q [QB+1];
  logic [DENW-1:0]   r_q   [QB+1];
  logic [QB-1:0]     q_q   [QB+1];
  logic [DENW-1:0]   den_q [QB+1];
  logic              neg_q [QB+1];
  logic              ovf_q [QB+1];
  kcet_pkg::ctl_t    ctl_q [QB+1];
  logic [EXW-1:0]    num_ext;
  logic [EXW-1:0]    den_sh;

  always_comb begin
    num_ext = EXW'(a_num_q);
    den_sh  = EXW'({a_den_q, {QB{1'b0}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q[0]   <= num_ext[QB +: DENW];
    q_q[0]   <= num_ext[QB-1:0];
    den_q[0] <= a_den_q;
    neg_q[0] <= a_neg_q;
    ovf_q[0] <= (num_ext >= den_sh);
    ctl_q[0] <= a_ctl_q;
  end

  // One quotient bit per stage, shifted in below the remaining dividend bits
  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [DENW:0] r2;
    logic [DENW:0] dx;
    logic          ge;

    assign r2 = {r_q[k-1], q_q[k-1][QB-1]};
    assign dx = {1'b0, den_q[k-1]};
    assign ge = (r2 >= dx);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      r_q[k]   <= ge ? DENW'(r2 - dx) : r2[DENW-1:0];
      q_q[k]   <= {q_q[k-1][QB-2:0], ge};
      den_q[k] <= den_q[k-1];
      neg_q[k] <= neg_q[k-1];
      ovf_q[k] <= ovf_q[k-1];
      ctl_q[k] <= ctl_q[k-1];
    end
  end

  // Floor toward minus infinity, saturate, select the result class
  logic              o_vld_q;
  logic [QB-1:0]     t_q;
  logic              inf_q;
  kcet_pkg::status_e st_q;
  logic [QB:0]       mag;
  logic [QB:0]       mag_sat;
  logic [QB-1:0]     t_d;

  always_comb begin
    mag = (QB+1)'(q_q[QB]) + (QB+1)'(neg_q[QB] && (r_q[QB] != '0));
    if (neg_q[QB]) begin
      mag_sat = (ovf_q[QB] || (mag > TMIN_MAG)) ? TMIN_MAG : mag;
    end else begin
      mag_sat = (ovf_q[QB] || (mag > TMAX_MAG)) ? TMAX_MAG : mag;
    end
    if (!ctl_q[QB].do_div) begin
      t_d = '0;
    end else if (neg_q[QB]) begin
      t_d = QB'(~mag_sat + 1'b1);
    end else begin
      t_d = mag_sat[QB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else begin
      o_vld_q <= vld_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    t_q   <= t_d;
    inf_q <= ctl_q[QB].inf;
    st_q  <= ctl_q[QB].st;
  end

  assign vld_o = o_vld_q;
  assign t_o   = t_q;
  assign inf_o = inf_q;
  assign st_o  = st_q;

endmodule
`default_nettype wire
